>>> rtl/ptk_pkg.sv
`timescale 1ns / 1ps

package ptk_pkg;

  localparam int unsigned SOURCES_DEF = 4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESEND     = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] HOLD_LIMIT_RST = 16'd180;
  localparam logic [7:0]  RESEND_RST     = 8'd2;

  // Item modes
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_POLL   = 1'b1;

  // Serial frame commands: on = F0 31 0A, off = F0 30 0A
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  localparam logic signed [7:0] PRI_NONE = -8'sd1;

  typedef struct packed {
    logic              mode;
    logic [2:0]        source_id;
    logic signed [7:0] source_priority;
    logic              source_request;
    logic [31:0]       now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0] serial_command;
    logic [2:0] reported_source;
    logic       keyed;
    logic [3:0] play_enable_mask;
    logic       timed_out;
  } out_item_t;

  // Arbitration result of a poll waiting for the keyer
  typedef struct packed {
    logic        valid;
    logic        any;
    logic        found;
    logic        stale;
    logic [31:0] now;
  } poll_ctl_t;

endpackage

>>> rtl/ptk_cell.sv
`timescale 1ns / 1ps

// One source: holds its priority and request flag, and passes the running
// best candidate on to the next cell.
module ptk_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned IDXW = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clear_i,
  input  logic                   upd_i,
  input  logic [2:0]             id_i,
  input  logic signed [7:0]      wr_pri_i,
  input  logic                   wr_req_i,
  input  logic                   any_i,
  input  logic                   found_i,
  input  logic signed [7:0]      best_pri_i,
  input  logic [IDXW-1:0]        best_idx_i,
  output logic                   any_o,
  output logic                   found_o,
  output logic signed [7:0]      best_pri_o,
  output logic [IDXW-1:0]        best_idx_o
);

  localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

  logic signed [7:0] pri_r, pri_nxt;
  logic              req_r, req_nxt;
  logic              hit;
  logic              take;

  assign hit = upd_i && (5'(id_i) == 5'(IDX + 1));

  always_comb begin
    pri_nxt = pri_r;
    req_nxt = req_r;
    if (clear_i) begin
      req_nxt = 1'b0;
    end
    // a write follows the clearing poll in order, so it wins
    if (hit) begin
      pri_nxt = wr_pri_i;
      req_nxt = wr_req_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pri_r <= ptk_pkg::PRI_NONE;
      req_r <= 1'b0;
    end else begin
      pri_r <= pri_nxt;
      req_r <= req_nxt;
    end
  end

  assign take       = req_r && (pri_r > best_pri_i);
  assign any_o      = any_i | req_r;
  assign found_o    = found_i | take;
  assign best_pri_o = take ? pri_r : best_pri_i;
  assign best_idx_o = take ? MY_IDX : best_idx_i;

endmodule

>>> rtl/ptk_keyer.sv
`timescale 1ns / 1ps

// Key state, hold timer and resend timer; owns the result register.
module ptk_keyer #(
  parameter int unsigned SOURCES = ptk_pkg::SOURCES_DEF,
  parameter int unsigned IDXW    = $clog2(SOURCES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptk_pkg::poll_ctl_t  poll_i,
  input  logic [IDXW-1:0]     chosen_i,
  input  logic [15:0]         hold_limit_i,
  input  logic [7:0]          resend_i,
  output logic                fire_o,
  output logic                clear_o,
  output logic                out_valid,
  input  logic                out_stall,
  output ptk_pkg::out_item_t  out_data
);

  logic [31:0]        hold_start_r, hold_start_nxt;
  logic               hold_run_r, hold_run_nxt;
  logic               key_sent_r, key_sent_nxt;
  logic [31:0]        last_send_r, last_send_nxt;
  logic [SOURCES-1:0] play_r, play_nxt;
  logic               out_valid_r, out_valid_nxt;
  ptk_pkg::out_item_t out_r, out_nxt;

  logic [31:0]        d_send, d_hold;
  logic               over_send, over_hold;
  logic               any_eff, expired;
  logic [7:0]         rep_full;
  logic [SOURCES+3:0] play_ext;

  // signed 32-bit wrap: a negative difference never exceeds a limit
  assign d_send    = poll_i.now - last_send_r;
  assign d_hold    = poll_i.now - hold_start_r;
  assign over_send = !d_send[31] && (d_send[30:0] > 31'(resend_i));
  assign over_hold = !d_hold[31] && (d_hold[30:0] > 31'(hold_limit_i));

  assign fire_o   = poll_i.valid && (!out_valid_r || !out_stall);
  assign any_eff  = poll_i.any && !poll_i.stale;
  assign expired  = any_eff && hold_run_r && over_hold;
  assign clear_o  = fire_o && expired;
  assign rep_full = 8'(chosen_i) + 8'd1;

  always_comb begin
    hold_start_nxt = hold_start_r;
    hold_run_nxt   = hold_run_r;
    key_sent_nxt   = key_sent_r;
    last_send_nxt  = last_send_r;
    play_nxt       = play_r;
    out_nxt        = out_r;
    out_nxt.serial_command  = ptk_pkg::CMD_NONE;
    out_nxt.reported_source = 3'd0;
    out_nxt.timed_out       = 1'b0;
    if (!any_eff || expired) begin
      if (key_sent_r || over_send) begin
        out_nxt.serial_command = ptk_pkg::CMD_OFF;
        key_sent_nxt  = 1'b0;
        last_send_nxt = poll_i.now;
      end
      hold_run_nxt = 1'b0;
      if (expired) begin
        out_nxt.timed_out = 1'b1;
      end else begin
        play_nxt = '0;
      end
    end else begin
      if (!hold_run_r) begin
        hold_start_nxt = poll_i.now;
        hold_run_nxt   = 1'b1;
      end
      if (!key_sent_r || over_send) begin
        out_nxt.serial_command = ptk_pkg::CMD_ON;
        key_sent_nxt  = 1'b1;
        last_send_nxt = poll_i.now;
        out_nxt.reported_source = poll_i.found ? rep_full[2:0] : 3'd0;
      end
      play_nxt = '0;
      if (poll_i.found) begin
        play_nxt[chosen_i] = 1'b1;
      end
    end
    play_ext                 = {4'b0000, play_nxt};
    out_nxt.keyed            = key_sent_nxt;
    out_nxt.play_enable_mask = play_ext[3:0];
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (fire_o) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_start_r <= '0;
      hold_run_r   <= 1'b0;
      key_sent_r   <= 1'b0;
      last_send_r  <= '0;
      play_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire_o) begin
        hold_start_r <= hold_start_nxt;
        hold_run_r   <= hold_run_nxt;
        key_sent_r   <= key_sent_nxt;
        last_send_r  <= last_send_nxt;
        play_r       <= play_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_o) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/ptt_priority_keyer.sv
`timescale 1ns / 1ps

// Push-to-talk keyer. Throughput: one transaction per cycle, updates and polls alike,
// unless a stalled result holds a poll in the arbitration register and stalls input.
// A poll reaches out_data through the arbitration and result registers; an update is
// seen by a poll accepted in the next cycle. The arbitration chain is combinational.
// Reset (rst_n low, synchronous) clears requests, priorities to -1, timers and
// key state, and restores hold limit 180 s and resend interval 2 s.
module ptt_priority_keyer #(
  parameter int unsigned SOURCES = ptk_pkg::SOURCES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ptk_pkg::in_item_t                   in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output ptk_pkg::out_item_t                  out_data,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ptk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptk_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned IDXW = $clog2(SOURCES);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] hold_limit_r;
  logic [7:0]  resend_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_limit_r <= ptk_pkg::HOLD_LIMIT_RST;
      resend_r     <= ptk_pkg::RESEND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ptk_pkg::CFG_HOLD_LIMIT: hold_limit_r <= cfg_data[15:0];
        ptk_pkg::CFG_RESEND:     resend_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Acceptance. A poll waits in the arbitration register until the keyer
  // takes it; while it waits nothing else is accepted, so a forced release
  // never wipes a request that came after the releasing poll.
  // ---------------------------------------------------------------------------
  logic in_acc, upd_acc, poll_acc;
  logic fire, clear;

  assign in_acc   = in_valid && !in_stall;
  assign upd_acc  = in_acc && (in_data.mode == ptk_pkg::MODE_UPDATE);
  assign poll_acc = in_acc && (in_data.mode == ptk_pkg::MODE_POLL);

  // ---------------------------------------------------------------------------
  // Cell chain: cell i holds source i+1; the best requester ripples from
  // cell 0 upwards, so a tie keeps the lower-numbered source.
  // ---------------------------------------------------------------------------
  logic                    any_c   [SOURCES+1];
  logic                    found_c [SOURCES+1];
  logic signed [7:0]       pri_c   [SOURCES+1];
  logic [IDXW-1:0]         idx_c   [SOURCES+1];

  assign any_c[0]   = 1'b0;
  assign found_c[0] = 1'b0;
  assign pri_c[0]   = ptk_pkg::PRI_NONE;
  assign idx_c[0]   = '0;

  for (genvar g = 0; g < SOURCES; g++) begin : g_cell
    ptk_cell #(
      .IDX  (g),
      .IDXW (IDXW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .clear_i    (clear),
      .upd_i      (upd_acc),
      .id_i       (in_data.source_id),
      .wr_pri_i   (in_data.source_priority),
      .wr_req_i   (in_data.source_request),
      .any_i      (any_c[g]),
      .found_i    (found_c[g]),
      .best_pri_i (pri_c[g]),
      .best_idx_i (idx_c[g]),
      .any_o      (any_c[g+1]),
      .found_o    (found_c[g+1]),
      .best_pri_o (pri_c[g+1]),
      .best_idx_o (idx_c[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Arbitration register. If the poll ahead forces release at the edge this
  // poll is captured, its view of the flags predates the clear: mark it stale
  // so the keyer treats it as having no requester.
  // ---------------------------------------------------------------------------
  ptk_pkg::poll_ctl_t s1_r, s1_nxt;
  logic [IDXW-1:0]    s1_idx_r;

  always_comb begin
    s1_nxt = s1_r;
    if (fire) begin
      s1_nxt.valid = 1'b0;
    end
    if (poll_acc) begin
      s1_nxt.valid = 1'b1;
      s1_nxt.any   = any_c[SOURCES];
      s1_nxt.found = found_c[SOURCES];
      s1_nxt.stale = clear;
      s1_nxt.now   = in_data.now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= s1_nxt.valid;
    end
    s1_r.any   <= s1_nxt.any;
    s1_r.found <= s1_nxt.found;
    s1_r.stale <= s1_nxt.stale;
    s1_r.now   <= s1_nxt.now;
    if (poll_acc) begin
      s1_idx_r <= idx_c[SOURCES];
    end
  end

  assign in_stall = s1_r.valid && !fire;

  // ---------------------------------------------------------------------------
  // Keyer and result register
  // ---------------------------------------------------------------------------
  ptk_keyer #(
    .SOURCES (SOURCES),
    .IDXW    (IDXW)
  ) u_keyer (
    .clk          (clk),
    .rst_n        (rst_n),
    .poll_i       (s1_r),
    .chosen_i     (s1_idx_r),
    .hold_limit_i (hold_limit_r),
    .resend_i     (resend_r),
    .fire_o       (fire),
    .clear_o      (clear),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

>>> rtl/ptk_checker.sv
`timescale 1ns / 1ps

module ptk_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input ptk_pkg::out_item_t out_data
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // off frame leaves the radio unkeyed and reports nobody
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.serial_command == ptk_pkg::CMD_OFF)
      |-> !out_data.keyed && (out_data.reported_source == 3'd0))
    else $error("off frame with key or source");

  // a forced release never leaves the radio keyed
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.timed_out |-> !out_data.keyed)
    else $error("timed out but still keyed");

  // at most one source plays
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_data.play_enable_mask))
    else $error("more than one source enabled");

  // no result straight after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind ptt_priority_keyer ptk_checker u_ptk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
